@@ rtl/ogru_pkg.sv @@
// Shared types and constants of the occupancy grid ray update unit.
// No dependencies; imported by all block files but ogru_map_mem.
`default_nettype none

package ogru_pkg;

    localparam int COORD_W     = 11;   // signed cell coordinate of a command
    localparam int INC_W       = 13;   // signed Q.8 increment
    localparam int CLAMP_W     = 23;   // signed Q.8 saturation limit
    localparam int CELLS_W     = 9;    // cells in use per side, cells touched
    localparam int VALUE_OUT_W = 23;   // signed Q.8 log-odds on the result

    // Command codes carried in tuser.
    localparam logic CMD_RAY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_HIT_INC    = 3'd0;
    localparam logic [2:0] REG_MISS_INC   = 3'd1;
    localparam logic [2:0] REG_CLAMP_LOW  = 3'd2;
    localparam logic [2:0] REG_CLAMP_HIGH = 3'd3;
    localparam logic [2:0] REG_CELLS_USED = 3'd4;

    // Register reset values.
    localparam logic signed [INC_W-1:0]   RST_HIT_INC    = 13'sd217;
    localparam logic signed [INC_W-1:0]   RST_MISS_INC   = -13'sd217;
    localparam logic signed [CLAMP_W-1:0] RST_CLAMP_LOW  = -23'sd1280;
    localparam logic signed [CLAMP_W-1:0] RST_CLAMP_HIGH = 23'sd1280000;
    localparam logic [CELLS_W-1:0]        RST_CELLS_USED = 9'd200;

    typedef struct packed {
        logic [INC_W-1:0]   hit_inc;
        logic [INC_W-1:0]   miss_inc;
        logic [CLAMP_W-1:0] clamp_low;
        logic [CLAMP_W-1:0] clamp_high;
        logic [CELLS_W-1:0] cells_used;
    } ogru_cfg_t;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               hit;
    } ogru_cmd_t;

    typedef struct packed {
        logic [VALUE_OUT_W-1:0] cell_value;
        logic [CELLS_W-1:0]     cells_updated;
    } ogru_result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLAMP,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } ogru_state_t;

endpackage

`default_nettype wire

@@ rtl/ogru_map_mem.sv @@
// Log-odds map storage: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and appears in the cycle after the read. No package dependencies.
`default_nettype none

module ogru_map_mem #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 23
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/ogru_sat_add.sv @@
// Saturating log-odds update: adds an increment, applies the clamp limits,
// then saturates to the stored value width. Depends on ogru_pkg.
`default_nettype none

module ogru_sat_add
    import ogru_pkg::*;
#(
    parameter int VALUE_WIDTH = 23
) (
    input  wire logic signed [VALUE_WIDTH-1:0] cur,
    input  wire logic signed [INC_W-1:0]       inc,
    input  wire logic signed [CLAMP_W-1:0]     lim_low,
    input  wire logic signed [CLAMP_W-1:0]     lim_high,
    output logic      signed [VALUE_WIDTH-1:0] result
);

    localparam int SW = ((VALUE_WIDTH > CLAMP_W) ? VALUE_WIDTH : CLAMP_W) + 2;
    localparam longint VMAX_L = (longint'(1) <<< (VALUE_WIDTH - 1)) - longint'(1);
    localparam logic signed [SW-1:0] VMAX = SW'(VMAX_L);
    localparam logic signed [SW-1:0] VMIN = SW'(-VMAX_L - longint'(1));

    logic signed [SW-1:0] sum_s;

    // The upper limit goes first, so crossed limits leave the lower one.
    always_comb
    begin
        sum_s = SW'(cur) + SW'(inc);
        if (sum_s > SW'(lim_high))
        begin
            sum_s = SW'(lim_high);
        end
        if (sum_s < SW'(lim_low))
        begin
            sum_s = SW'(lim_low);
        end
        if (sum_s > VMAX)
        begin
            sum_s = VMAX;
        end
        if (sum_s < VMIN)
        begin
            sum_s = VMIN;
        end
        result = sum_s[VALUE_WIDTH-1:0];
    end

endmodule

`default_nettype wire

@@ rtl/ogru_ray_walker.sv @@
// Command sequencer: map clearing pass, coordinate clamping, Bresenham stepping
// and the read-modify-write pipeline on the map RAM. Depends on ogru_pkg, ogru_sat_add.
`default_nettype none

module ogru_ray_walker
    import ogru_pkg::*;
#(
    parameter int GRID_SIDE   = 256,
    parameter int VALUE_WIDTH = 23
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ogru_cfg_t                           cfg,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire ogru_cmd_t                           cmd,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output ogru_result_t                             res,
    output logic                                     mem_we,
    output logic [2*$clog2(GRID_SIDE)-1:0]           mem_waddr,
    output logic [VALUE_WIDTH-1:0]                   mem_wdata,
    output logic                                     mem_re,
    output logic [2*$clog2(GRID_SIDE)-1:0]           mem_raddr,
    input  wire logic [VALUE_WIDTH-1:0]              mem_rdata
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int AW    = 2 * CW;
    localparam int EW    = CW + 2;
    localparam int CNT_W = ((CW + 1) > CELLS_W) ? (CW + 1) : CELLS_W;

    ogru_state_t state_reg, state_next;
    ogru_cmd_t   cmd_reg, cmd_next;

    logic [CW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [CW-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [CW-1:0] a_reg, a_next, b_reg, b_next;
    logic [CW-1:0] da_reg, da_next, db_reg, db_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic          steep_reg, steep_next;
    logic          a_dec_reg, a_dec_next, b_dec_reg, b_dec_next;
    logic          p_valid_reg, p_valid_next, p_last_reg, p_last_next;
    logic [AW-1:0] p_addr_reg, p_addr_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [VALUE_OUT_W-1:0] val_reg, val_next;

    logic [COORD_W-1:0] lim_c, top_c, n_c;
    logic [CW-1:0] adx_c, ady_c, cx_c, cy_c;
    logic          steep_c;
    logic signed [EW-1:0] err_sub_c;
    logic [CNT_W-1:0] cells_c;
    logic signed [VALUE_WIDTH-1:0] upd_c;
    logic signed [INC_W-1:0] inc_c;

    function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                  input logic [COORD_W-1:0] top);
        logic [CW-1:0] r;
        if (v[COORD_W-1])
        begin
            r = '0;
        end
        else if (v > top)
        begin
            r = top[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic [VALUE_OUT_W-1:0] to_out(input logic signed [VALUE_WIDTH-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[VALUE_OUT_W-1:0];
    endfunction

    // Top coordinate of the grid in use.
    always_comb
    begin
        n_c = COORD_W'(cfg.cells_used);
        if (n_c == '0)
        begin
            lim_c = COORD_W'(1);
        end
        else if (n_c > COORD_W'(GRID_SIDE))
        begin
            lim_c = COORD_W'(GRID_SIDE);
        end
        else
        begin
            lim_c = n_c;
        end
        top_c = lim_c - COORD_W'(1);
    end

    assign adx_c   = (ex_reg > sx_reg) ? (ex_reg - sx_reg) : (sx_reg - ex_reg);
    assign ady_c   = (ey_reg > sy_reg) ? (ey_reg - sy_reg) : (sy_reg - ey_reg);
    assign steep_c = ady_c > adx_c;

    assign cx_c      = steep_reg ? b_reg : a_reg;
    assign cy_c      = steep_reg ? a_reg : b_reg;
    assign err_sub_c = err_reg - $signed({2'b00, db_reg});
    assign cells_c   = CNT_W'(da_reg) + CNT_W'(1);

    assign inc_c = (p_last_reg && cmd_reg.hit) ? $signed(cfg.hit_inc) : $signed(cfg.miss_inc);

    ogru_sat_add #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_sat_add (
        .cur      ($signed(mem_rdata)),
        .inc      (inc_c),
        .lim_low  ($signed(cfg.clamp_low)),
        .lim_high ($signed(cfg.clamp_high)),
        .result   (upd_c)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        ex_next      = ex_reg;
        ey_next      = ey_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        da_next      = da_reg;
        db_next      = db_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        steep_next   = steep_reg;
        a_dec_next   = a_dec_reg;
        b_dec_next   = b_dec_reg;
        p_valid_next = 1'b0;
        p_last_next  = p_last_reg;
        p_addr_next  = p_addr_reg;
        clr_next     = clr_reg;
        val_next     = val_reg;

        cmd_ready = 1'b0;
        res_valid = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = {cy_c, cx_c};

        // Write stage: the cell read in the previous cycle is updated now.
        mem_we    = p_valid_reg;
        mem_waddr = p_addr_reg;
        mem_wdata = upd_c;
        if (p_valid_reg && p_last_reg)
        begin
            val_next = to_out(upd_c);
        end

        res.cell_value    = val_reg;
        res.cells_updated = (cmd_reg.command == CMD_READ) ? '0 : cells_c[CELLS_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                sx_next    = clamp_coord(cmd_reg.cell_x, top_c);
                sy_next    = clamp_coord(cmd_reg.cell_y, top_c);
                ex_next    = clamp_coord(cmd_reg.end_x, top_c);
                ey_next    = clamp_coord(cmd_reg.end_y, top_c);
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                if (cmd_reg.command == CMD_READ)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {sy_reg, sx_reg};
                    state_next = ST_READ;
                end
                else
                begin
                    // Steep lines walk along y, so the a axis is always the major one.
                    steep_next = steep_c;
                    a_next     = steep_c ? sy_reg : sx_reg;
                    b_next     = steep_c ? sx_reg : sy_reg;
                    da_next    = steep_c ? ady_c : adx_c;
                    db_next    = steep_c ? adx_c : ady_c;
                    cnt_next   = steep_c ? ady_c : adx_c;
                    a_dec_next = steep_c ? !(sy_reg < ey_reg) : !(sx_reg < ex_reg);
                    b_dec_next = steep_c ? !(sx_reg < ex_reg) : !(sy_reg < ey_reg);
                    err_next   = $signed({2'b00, (steep_c ? ady_c : adx_c) >> 1});
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                mem_re       = 1'b1;
                p_valid_next = 1'b1;
                p_addr_next  = {cy_c, cx_c};
                p_last_next  = (cnt_reg == '0);
                a_next       = a_dec_reg ? (a_reg - CW'(1)) : (a_reg + CW'(1));
                cnt_next     = cnt_reg - CW'(1);
                if (err_sub_c < 0)
                begin
                    b_next   = b_dec_reg ? (b_reg - CW'(1)) : (b_reg + CW'(1));
                    err_next = err_sub_c + $signed({2'b00, da_reg});
                end
                else
                begin
                    err_next = err_sub_c;
                end
                if (cnt_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                val_next   = to_out($signed(mem_rdata));
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        da_reg     <= da_next;
        db_reg     <= db_next;
        cnt_reg    <= cnt_next;
        err_reg    <= err_next;
        steep_reg  <= steep_next;
        a_dec_reg  <= a_dec_next;
        b_dec_reg  <= b_dec_next;
        p_last_reg <= p_last_next;
        p_addr_reg <= p_addr_next;
        val_reg    <= val_next;
    end

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("map written while the sequencer is idle");

    a_no_rw_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same map cell in one cycle");

    a_walk_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && cnt_reg != '0) |=>
        (state_reg == ST_WALK && cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("ray step counter out of sequence");

    a_last_cell_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && cnt_reg == '0) |=>
        (state_reg == ST_DRAIN && p_valid_reg && p_last_reg))
        else $error("end cell not in the write stage after the last step");
`endif

endmodule

`default_nettype wire

@@ rtl/occupancy_grid_ray_update_unit.sv @@
// Top level of the occupancy grid ray update unit: register port, stream ports,
// output register. Depends on ogru_pkg, ogru_map_mem, ogru_sat_add, ogru_ray_walker.
//
//   Port group   Direction  Carries
//   s_axis_*     in         one command word: ray trace and update, or cell read
//   m_axis_*     out        one result word per command
//   APB          in/out     five configuration registers at byte addresses 0..16
//
// A ray passes through accept, clamp, setup, one walk step per cell on the line (a read
// of the map RAM pipelined against the write of the previous cell), a drain step for
// the end cell's write, and hand-off to the output register. A read passes through
// accept, clamp, setup, a map RAM read and hand-off. The registered map RAM read sets
// the pace of one cell per cycle. After reset the map is cleared one entry a cycle,
// all 2**(2*clog2(GRID_SIDE)) entries (65536 at the default size), while no
// command is accepted; register writes are taken throughout. A new command is
// accepted while a finished result still waits in the output register.
`default_nettype none

module occupancy_grid_ray_update_unit
    import ogru_pkg::*;
#(
    parameter int GRID_SIDE   = 256,
    parameter int VALUE_WIDTH = 23
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // tdata: cell_x[10:0], cell_y[21:11], end_x[32:22], end_y[43:33], hit[44], zero[47:45]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    // tuser: command[0]
    input  wire logic        s_axis_tuser,

    // tdata: cell_value[22:0], cells_updated[31:23]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = 2 * $clog2(GRID_SIDE);

    // Configuration registers, kept as raw two's complement bits.
    logic [INC_W-1:0]   hit_inc_reg, miss_inc_reg;
    logic [CLAMP_W-1:0] clamp_low_reg, clamp_high_reg;
    logic [CELLS_W-1:0] cells_used_reg;
    logic               cfg_wr;
    ogru_cfg_t          cfg;

    ogru_cmd_t    cmd;
    ogru_result_t res;
    logic         res_valid, res_ready;

    // Output register that decouples the sequencer from the result consumer.
    logic         out_valid_reg, out_valid_next;
    ogru_result_t out_data_reg, out_data_next;

    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_inc_reg    <= RST_HIT_INC;
            miss_inc_reg   <= RST_MISS_INC;
            clamp_low_reg  <= RST_CLAMP_LOW;
            clamp_high_reg <= RST_CLAMP_HIGH;
            cells_used_reg <= RST_CELLS_USED;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_HIT_INC:    hit_inc_reg    <= pwdata[INC_W-1:0];
                REG_MISS_INC:   miss_inc_reg   <= pwdata[INC_W-1:0];
                REG_CLAMP_LOW:  clamp_low_reg  <= pwdata[CLAMP_W-1:0];
                REG_CLAMP_HIGH: clamp_high_reg <= pwdata[CLAMP_W-1:0];
                REG_CELLS_USED: cells_used_reg <= pwdata[CELLS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register reads return the stored bits, zero extended.
    always_comb
    begin
        case (paddr[4:2])
            REG_HIT_INC:    prdata = 32'(hit_inc_reg);
            REG_MISS_INC:   prdata = 32'(miss_inc_reg);
            REG_CLAMP_LOW:  prdata = 32'(clamp_low_reg);
            REG_CLAMP_HIGH: prdata = 32'(clamp_high_reg);
            REG_CELLS_USED: prdata = 32'(cells_used_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.hit_inc    = hit_inc_reg;
    assign cfg.miss_inc   = miss_inc_reg;
    assign cfg.clamp_low  = clamp_low_reg;
    assign cfg.clamp_high = clamp_high_reg;
    assign cfg.cells_used = cells_used_reg;

    // Unpack the command word.
    assign cmd.command = s_axis_tuser;
    assign cmd.cell_x  = s_axis_tdata[10:0];
    assign cmd.cell_y  = s_axis_tdata[21:11];
    assign cmd.end_x   = s_axis_tdata[32:22];
    assign cmd.end_y   = s_axis_tdata[43:33];
    assign cmd.hit     = s_axis_tdata[44];

    ogru_ray_walker #(
        .GRID_SIDE   (GRID_SIDE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ray_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Map entries are addressed as {row, column}.
    ogru_map_mem #(
        .ADDR_W (AW),
        .DATA_W (VALUE_WIDTH)
    ) u_map_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The slot frees up in the same cycle that the consumer takes the word.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.cells_updated, out_data_reg.cell_value};

endmodule

`default_nettype wire

@@ tb/log_odds_checker.sv @@
// Checker for the occupancy grid ray update unit: keeps its own log-odds map and
// register copies, predicts each result word and compares it. Depends on ogru_pkg.
`default_nettype none

module log_odds_checker
    import ogru_pkg::*;
#(
    parameter int GRID_SIDE   = 256,
    parameter int VALUE_WIDTH = 23
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               mismatch_count,
    output int               results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [INC_W-1:0]   hit_inc;
    logic signed [INC_W-1:0]   miss_inc;
    logic signed [CLAMP_W-1:0] sat_low;
    logic signed [CLAMP_W-1:0] sat_high;
    logic [CELLS_W-1:0]        side_used;

    int           grid_map [GRID_SIDE*GRID_SIDE];
    ogru_result_t expected_results [$];

    function automatic int side_in_use();
        int n;
        n = int'(side_used);
        if (n < 1) n = 1;
        if (n > GRID_SIDE) n = GRID_SIDE;
        return n;
    endfunction

    function automatic int clamp_coord(logic [COORD_W-1:0] raw);
        int v;
        v = int'($signed(raw));
        if (v < 0) v = 0;
        if (v > side_in_use() - 1) v = side_in_use() - 1;
        return v;
    endfunction

    // Saturating add: register clamps first (upper, then lower), then storage width.
    function automatic void add_log_odds(int x, int y, longint inc);
        longint vmax;
        longint vmin;
        longint s;
        vmax = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
        vmin = -vmax - 1;
        s = longint'(grid_map[y*GRID_SIDE + x]) + inc;
        if (s > longint'(sat_high)) s = longint'(sat_high);
        if (s < longint'(sat_low)) s = longint'(sat_low);
        if (s > vmax) s = vmax;
        if (s < vmin) s = vmin;
        grid_map[y*GRID_SIDE + x] = int'(s);
    endfunction

    function automatic ogru_result_t predict_result(ogru_cmd_t c);
        ogru_result_t r;
        int sx, sy, ex, ey, adx, ady;
        int a, b, a1, b1, da, db, astep, bstep, err, cx, cy, k;
        int value, count;
        bit steep;
        longint inc;
        sx = clamp_coord(c.cell_x);
        sy = clamp_coord(c.cell_y);
        count = 0;
        if (c.command == CMD_READ) begin
            value = grid_map[sy*GRID_SIDE + sx];
        end else begin
            ex = clamp_coord(c.end_x);
            ey = clamp_coord(c.end_y);
            adx = (ex > sx) ? ex - sx : sx - ex;
            ady = (ey > sy) ? ey - sy : sy - ey;
            steep = (ady > adx);
            a  = steep ? sy : sx;
            b  = steep ? sx : sy;
            a1 = steep ? ey : ex;
            b1 = steep ? ex : ey;
            da = steep ? ady : adx;
            db = steep ? adx : ady;
            astep = (a < a1) ? 1 : -1;
            bstep = (b < b1) ? 1 : -1;
            err = da / 2;
            for (k = 0; k <= da; k++) begin
                cx = steep ? b : a;
                cy = steep ? a : b;
                inc = (k == da && c.hit) ? longint'(hit_inc) : longint'(miss_inc);
                add_log_odds(cx, cy, inc);
                err -= db;
                if (err < 0) begin
                    b += bstep;
                    err += da;
                end
                a += astep;
            end
            count = da + 1;
            value = grid_map[ey*GRID_SIDE + ex];
        end
        r.cell_value    = value[VALUE_OUT_W-1:0];
        r.cells_updated = count[CELLS_W-1:0];
        return r;
    endfunction

    function automatic ogru_cmd_t unpack_command(logic [47:0] data, logic user);
        ogru_cmd_t c;
        c.command = user;
        c.cell_x  = data[10:0];
        c.cell_y  = data[21:11];
        c.end_x   = data[32:22];
        c.end_y   = data[43:33];
        c.hit     = data[44];
        return c;
    endfunction

    task automatic report_mismatch(string field, int expected, int observed);
        mismatch_count++;
        $display("%0t ns ERROR %s: expected %0d, observed %0d", $time, field, expected,
                 observed);
    endtask

    always @(posedge clk) begin : observe
        ogru_result_t want;
        ogru_result_t got;
        if (!rst_n) begin
            hit_inc   = RST_HIT_INC;
            miss_inc  = RST_MISS_INC;
            sat_low   = RST_CLAMP_LOW;
            sat_high  = RST_CLAMP_HIGH;
            side_used = RST_CELLS_USED;
            mismatch_count = 0;
            expected_results.delete();
            results_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_HIT_INC:    hit_inc   = pwdata[INC_W-1:0];
                    REG_MISS_INC:   miss_inc  = pwdata[INC_W-1:0];
                    REG_CLAMP_LOW:  sat_low   = pwdata[CLAMP_W-1:0];
                    REG_CLAMP_HIGH: sat_high  = pwdata[CLAMP_W-1:0];
                    REG_CELLS_USED: side_used = pwdata[CELLS_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.cell_value    = m_axis_tdata[22:0];
                got.cells_updated = m_axis_tdata[31:23];
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with no command pending", 0,
                                    int'($signed(got.cell_value)));
                end else begin
                    want = expected_results.pop_front();
                    if (got.cell_value !== want.cell_value)
                        report_mismatch("cell_value", int'($signed(want.cell_value)),
                                        int'($signed(got.cell_value)));
                    if (got.cells_updated !== want.cells_updated)
                        report_mismatch("cells_updated", int'(want.cells_updated),
                                        int'(got.cells_updated));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.insert(expected_results.size(),
                    predict_result(unpack_command(s_axis_tdata, s_axis_tuser)));
            results_pending <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/occupancy_grid_ray_update_unit_tb.sv @@
// Testbench top of the occupancy grid ray update unit: clock, reset, register
// writes, command words and result back-pressure. Depends on ogru_pkg, the RTL
// and log_odds_checker, which predicts and compares every result word.
`default_nettype none

module occupancy_grid_ray_update_unit_tb;
    import ogru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // No word is accepted during the map clear after reset, so the watchdog limit
    // sits well above the length of that clear.
    localparam int STALL_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 300;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: cell_x[10:0], cell_y[21:11], end_x[32:22], end_y[43:33], hit[44], zero[47:45]
    logic [47:0] s_axis_tdata  = '0;
    // tuser: command[0]
    logic        s_axis_tuser  = 1'b0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: cell_value[22:0], cells_updated[31:23]
    logic [31:0] m_axis_tdata;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int results_pending;
    int watchdog_cycles = 0;
    int ready_hold_off  = 0;
    // When set, neither the command side nor the result side inserts gaps.
    bit steady_flow     = 1'b0;

    always #6 clk = ~clk;

    occupancy_grid_ray_update_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    log_odds_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int gap_cycles();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Result side: ready by default, dropped for random stretches.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (ready_hold_off > 0) begin
            ready_hold_off--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 35)
                ready_hold_off = gap_cycles();
        end
    end

    // Watchdog: any accepted word on any port restarts the count.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            watchdog_cycles <= 0;
        end else if (watchdog_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            watchdog_cycles <= watchdog_cycles + 1;
        end
    end

    // Offer one command word and hold it until the block takes it. A zero gap
    // keeps tvalid high straight into the next word.
    task automatic send_command(logic cmd, int cx, int cy, int ex, int ey, logic hit);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, hit, COORD_W'(ey), COORD_W'(ex), COORD_W'(cy),
                          COORD_W'(cx)};
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Stop offering words until every result word has come back. The first
    // edge lets the pending count catch up with the last accepted command.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_register(logic [2:0] index, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly coordinates around the grid in use (including just off either
    // edge), sometimes anything the 11-bit field can hold.
    function automatic int random_coord(int span);
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(0, span + 3)) - 2;
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    task automatic run_random(int count, int span);
        int i, cx, cy, ex, ey;
        logic cmd;
        for (i = 0; i < count; i++) begin
            // Now and then the sender pauses until the block has drained.
            if ($urandom_range(0, 99) < 2)
                wait_drained();
            cmd = ($urandom_range(0, 99) < 25) ? CMD_READ : CMD_RAY;
            cx = random_coord(span);
            cy = random_coord(span);
            ex = random_coord(span);
            ey = random_coord(span);
            if ($urandom_range(0, 99) < 8) begin
                ex = cx;
                ey = cy;
            end
            send_command(cmd, cx, cy, ex, ey, 1'($urandom_range(0, 1)));
        end
    endtask

    // One setting of all five registers, written while the block is idle, and
    // a burst of random words under it.
    task automatic run_phase(int hit_inc, int miss_inc, int sat_low, int sat_high,
                             int cells, int count);
        int span;
        wait_drained();
        write_register(REG_HIT_INC, hit_inc);
        write_register(REG_MISS_INC, miss_inc);
        write_register(REG_CLAMP_LOW, sat_low);
        write_register(REG_CLAMP_HIGH, sat_high);
        write_register(REG_CELLS_USED, cells);
        span = (cells < 1) ? 1 : ((cells > 256) ? 256 : cells);
        run_random(count, span);
    endtask

    initial begin
        int k;
        int lo, hi;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings (200 cells per side).
        send_command(CMD_READ, 0, 0, 0, 0, 1'b0);          // freshly cleared cell
        send_command(CMD_RAY, 5, 5, 5, 5, 1'b1);           // zero-length ray, hit
        send_command(CMD_RAY, 6, 6, 6, 6, 1'b0);           // zero-length ray, miss
        send_command(CMD_READ, 5, 5, 0, 0, 1'b1);
        send_command(CMD_RAY, 0, 10, 20, 10, 1'b1);        // horizontal, rightward
        send_command(CMD_RAY, 20, 12, 0, 12, 1'b0);        // horizontal, leftward
        send_command(CMD_RAY, 30, 0, 30, 40, 1'b1);        // vertical, steep swap
        send_command(CMD_RAY, 31, 40, 31, 0, 1'b1);        // vertical, upward
        send_command(CMD_RAY, 0, 50, 60, 70, 1'b1);        // shallow slope
        send_command(CMD_RAY, 70, 0, 80, 90, 1'b1);        // steep slope
        send_command(CMD_RAY, 90, 90, 85, 20, 1'b0);       // steep, both steps negative
        // Both ends far off the grid: clamps to the full 200-cell diagonal.
        send_command(CMD_RAY, -1024, -1024, 1023, 1023, 1'b1);
        send_command(CMD_RAY, 1023, -1024, -1024, 1023, 1'b0);
        send_command(CMD_READ, 1023, 1023, 0, 0, 1'b0);
        send_command(CMD_READ, -1024, -1024, 1023, 1023, 1'b1);
        // Repeated misses on one cell drive it into the lower clamp.
        for (k = 0; k < 7; k++)
            send_command(CMD_RAY, 100, 100, 100, 100, 1'b0);
        // Reads with alternating bit patterns, first in the fields ignored, then in the cell fields.
        send_command(CMD_READ, 100, 100, 1365, 682, 1'b1);
        send_command(CMD_READ, 682, 1365, 682, 1365, 1'b0);

        // Register settings, the extremes among them.
        run_phase(217, -217, -1280, 1280000, 200, 120);
        run_phase(4095, -4096, -4194304, 4194303, 256, 60);
        run_phase(-4096, 4095, -5000, 5000, 16, 150);
        run_phase(300, -50, 1000, -1000, 8, 100);           // crossed clamps
        run_phase(100, -100, -3000, 3000, 0, 60);           // zero acts as one cell
        run_phase(-700, 900, -4194304, 4194303, 511, 60);   // above the grid side
        run_phase(1, 1, -100, 40000, 1, 50);
        steady_flow = 1'b1;
        run_phase(217, -217, -1280, 1280000, 24, 150);
        steady_flow = 1'b0;
        for (k = 0; k < 4; k++) begin
            if ($urandom_range(0, 1) == 1) begin
                lo = -int'($urandom_range(0, 20000));
                hi = int'($urandom_range(0, 20000));
            end else begin
                lo = int'($urandom_range(0, 8388607)) - 4194304;
                hi = int'($urandom_range(0, 8388607)) - 4194304;
            end
            run_phase(int'($urandom_range(0, 8191)) - 4096,
                      int'($urandom_range(0, 8191)) - 4096,
                      lo, hi, $urandom_range(2, 40), 110);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/ogru_pkg.sv
rtl/ogru_map_mem.sv
rtl/ogru_sat_add.sv
rtl/ogru_ray_walker.sv
rtl/occupancy_grid_ray_update_unit.sv
tb/log_odds_checker.sv
tb/occupancy_grid_ray_update_unit_tb.sv
